### hdl/lspb_pkg.sv
// Package: shared types, codes and constants of the lidar scan packet binner.
`timescale 1ns / 1ps

package lspb_pkg;

	// Table geometry
	localparam int TABLE_SPAN = 256;
	localparam int IDX_W      = (TABLE_SPAN > 1) ? $clog2(TABLE_SPAN) : 1;
	localparam int ADDR_W     = IDX_W + 1;

	// Field widths
	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int RIDX_W   = 8;
	localparam int QUAL_W   = 6;
	localparam int WIN_W    = 9;
	localparam int ANGLE_W  = 15;
	localparam int DIST_W   = 14;
	localparam int CM_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// Millimeter to centimeter scaling by reciprocal multiplication
	// (exact for every quotient below the saturation point)
	localparam int CM_DIVISOR  = 10;
	localparam int SAT_MM      = CM_DIVISOR * (2 ** CM_W);
	localparam int MM_W        = $clog2(SAT_MM);
	localparam int RECIP_SHIFT = 14;
	localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + CM_DIVISOR - 1) / CM_DIVISOR;
	localparam int RECIP_W     = $clog2(RECIP_MUL + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_QUAL_THR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_BYTE  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_QUALITY  = 3'd0,
		PH_ANGLE_LO = 3'd1,
		PH_ANGLE_HI = 3'd2,
		PH_DIST_LO  = 3'd3,
		PH_DIST_HI  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_EXEC  = 3'd1,
		ST_DIV   = 3'd2,
		ST_FIN   = 3'd3,
		ST_CLEAR = 3'd4
	} state_t;

	// Sequencer strobes
	typedef struct packed {
		logic take;
		logic exec;
		logic div_start;
		logic scan_start;
		logic wr_en;
		logic clr_en;
		logic load_out;
	} seq_ctl_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [DIST_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [CM_W-1:0] quotient;
	} div_rsp_t;

endpackage

### hdl/lspb_if.sv
// Interfaces: request channel and result channel of the lidar scan packet binner.
`timescale 1ns / 1ps

interface lspb_item_if;
	import lspb_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] byte_value;
	logic [RIDX_W-1:0] read_index;

	modport source (output valid, command, byte_value, read_index, input ready);
	modport sink   (input valid, command, byte_value, read_index, output ready);
endinterface

interface lspb_result_if;
	import lspb_pkg::*;
	logic            valid;
	logic            ready;
	logic [CM_W-1:0] read_data;
	logic            frame_ready;
	logic            scan_started;
	logic            point_stored;
	logic            sync_error;

	modport source (output valid, read_data, frame_ready, scan_started, point_stored,
		sync_error, input ready);
	modport sink   (input valid, read_data, frame_ready, scan_started, point_stored,
		sync_error, output ready);
endinterface

### hdl/lspb_div.sv
// Shared scaling unit: millimeters to centimeters by reciprocal multiplication, saturated.
`timescale 1ns / 1ps

module lspb_div (
	input  logic                clk,
	input  logic                arst_n,
	input  lspb_pkg::div_req_t  req,
	output lspb_pkg::div_rsp_t  rsp
);
	import lspb_pkg::*;

	logic                      done_q;
	logic [CM_W-1:0]           quo_q;
	logic                      sat;
	logic [MM_W-1:0]           mm;
	logic [MM_W+RECIP_W-1:0]   prod;

	// Anything at or above 256.0 cm saturates
	assign sat  = (req.dividend >= DIST_W'(SAT_MM));
	assign mm   = req.dividend[MM_W-1:0];
	assign prod = (MM_W+RECIP_W)'(mm) * (MM_W+RECIP_W)'(RECIP_MUL);

	// Control: done is registered, so the result is ready in the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req.start;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= sat ? {CM_W{1'b1}} : prod[RECIP_SHIFT +: CM_W];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### hdl/lidar_scan_packet_binner.sv
// Top level: lidar packet decoder with live and snapshot angle tables.
// A request is taken in idle, executed the next cycle and its result registered in the finish
// state once the result register is free; a distance high byte first waits in the divide state
// for the shared scaler, and a scan start first walks the clearing state, one table entry per
// cycle, to clear the new live bank. One request at a time: not ready until the result register is loaded.
// Reset (arst_n, asynchronous) clears sequencer, decoder and flags, then a clearing pass zeroes both banks.
`timescale 1ns / 1ps

module lidar_scan_packet_binner (
	input  logic                              clk,
	input  logic                              arst_n,
	lspb_item_if.sink                         item,
	lspb_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [lspb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lspb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lspb_pkg::*;

	state_t            state_q, state_d;
	seq_ctl_t          ctl;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// Configuration
	logic [QUAL_W-1:0] thr_q;
	logic [WIN_W-1:0]  win_q;

	// Latched request
	cmd_t              cmd_q;
	logic [BYTE_W-1:0] byte_q;
	logic [RIDX_W-1:0] ridx_q;

	// Decoder state
	phase_t             phase_q;
	logic [QUAL_W-1:0]  quality_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [DIST_W-1:0]  dist_q;
	logic               frame_ready_q;
	logic               bank_q;

	// Clearing walker
	logic               boot_q;
	logic               clr_hi_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic               clr_last;
	logic [ADDR_W-1:0]  clr_addr;

	// Per-request event flags
	logic started_q;
	logic stored_q;
	logic serr_q;

	// Table memory: live bank is bank_q, snapshot bank is the other one
	logic [CM_W-1:0] tbl_mem [2**ADDR_W];
	logic [CM_W-1:0] rd_data_q;
	logic            rd_ok_q;

	// Result register
	logic            out_valid_q;
	logic [CM_W-1:0] out_data_q;
	logic            out_fr_q;
	logic            out_st_q;
	logic            out_sp_q;
	logic            out_se_q;
	logic            out_free;

	// Derived datapath values
	logic [DIST_W-1:0]  dist_full;
	logic [WIN_W-1:0]   deg;
	logic [WIN_W:0]     off;
	logic               in_win;
	logic [IDX_W-1:0]   rd_idx;
	logic               rd_in_span;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;

	assign dist_full  = dist_q | {byte_q, 6'b0};
	assign deg        = angle_q[ANGLE_W-1 -: WIN_W];
	assign off        = {1'b0, deg} - {1'b0, win_q};
	assign in_win     = !off[WIN_W] && (off < (WIN_W+1)'(TABLE_SPAN)) && (quality_q >= thr_q);
	assign rd_idx     = IDX_W'(ridx_q);
	assign rd_in_span = (int'(ridx_q) < TABLE_SPAN);
	assign wr_addr    = {bank_q, off[IDX_W-1:0]};
	assign rd_addr    = {~bank_q, rd_idx};
	assign out_free   = !out_valid_q || result.ready;

	// Last entry of a clearing pass; the boot pass covers both banks
	assign clr_last = (clr_idx_q == IDX_W'(TABLE_SPAN - 1)) && !(boot_q && !clr_hi_q);
	assign clr_addr = {clr_hi_q, clr_idx_q};

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (item.valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (ctl.div_start) begin
					state_d = ST_DIV;
				end else if (ctl.scan_start) begin
					state_d = ST_CLEAR;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV:   if (div_rsp.done) state_d = ST_FIN;
			ST_CLEAR: if (clr_last) state_d = boot_q ? ST_IDLE : ST_FIN;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer: strobes
	always_comb begin
		ctl            = '0;
		ctl.take       = (state_q == ST_IDLE);
		ctl.exec       = (state_q == ST_EXEC);
		ctl.div_start  = ctl.exec && (cmd_q == CMD_BYTE) && (phase_q == PH_DIST_HI);
		ctl.scan_start = ctl.exec && (cmd_q == CMD_BYTE) && (phase_q == PH_QUALITY) &&
			byte_q[0] && !byte_q[1];
		ctl.wr_en      = (state_q == ST_DIV) && div_rsp.done && in_win;
		ctl.clr_en     = (state_q == ST_CLEAR);
		ctl.load_out   = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign item.ready = ctl.take;

	// Shared divider
	assign div_req.start    = ctl.div_start;
	assign div_req.dividend = dist_full;

	lspb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			win_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUAL_THR:  thr_q <= cfg_data[QUAL_W-1:0];
				CFG_WIN_START: win_q <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Request latch
	always_ff @(posedge clk) begin
		if (ctl.take && item.valid) begin
			cmd_q  <= cmd_t'(item.command);
			byte_q <= item.byte_value;
			ridx_q <= item.read_index;
		end
	end

	// Clearing walker: both banks after reset, the new live bank on a scan start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q    <= 1'b1;
			clr_hi_q  <= 1'b0;
			clr_idx_q <= '0;
		end else if (ctl.scan_start) begin
			clr_hi_q  <= ~bank_q;
			clr_idx_q <= '0;
		end else if (ctl.clr_en) begin
			if (clr_last) begin
				boot_q    <= 1'b0;
				clr_idx_q <= '0;
			end else if (clr_idx_q == IDX_W'(TABLE_SPAN - 1)) begin
				clr_hi_q  <= 1'b1;
				clr_idx_q <= '0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// Decoder, flags and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_QUALITY;
			quality_q     <= '0;
			angle_q       <= '0;
			dist_q        <= '0;
			frame_ready_q <= 1'b0;
			bank_q        <= 1'b0;
			started_q     <= 1'b0;
			stored_q      <= 1'b0;
			serr_q        <= 1'b0;
		end else begin
			if (ctl.take && item.valid) begin
				started_q <= 1'b0;
				stored_q  <= 1'b0;
				serr_q    <= 1'b0;
			end
			if (ctl.exec) begin
				case (cmd_q)
					CMD_BYTE: begin
						case (phase_q)
							PH_QUALITY: begin
								if (byte_q[0] == byte_q[1]) begin
									serr_q <= 1'b1;
								end else begin
									quality_q <= byte_q[BYTE_W-1:2];
									phase_q   <= PH_ANGLE_LO;
									// Scan start: swap banks, the walker empties the new live bank
									if (byte_q[0]) begin
										bank_q        <= ~bank_q;
										frame_ready_q <= 1'b1;
										started_q     <= 1'b1;
									end
								end
							end
							PH_ANGLE_LO: begin
								if (!byte_q[0]) begin
									serr_q  <= 1'b1;
									phase_q <= PH_QUALITY;
								end else begin
									angle_q <= ANGLE_W'(byte_q[BYTE_W-1:1]);
									phase_q <= PH_ANGLE_HI;
								end
							end
							PH_ANGLE_HI: begin
								angle_q <= angle_q | {byte_q, 7'b0};
								phase_q <= PH_DIST_LO;
							end
							PH_DIST_LO: begin
								dist_q  <= DIST_W'(byte_q[BYTE_W-1:2]);
								phase_q <= PH_DIST_HI;
							end
							PH_DIST_HI: begin
								dist_q  <= dist_full;
								phase_q <= PH_QUALITY;
							end
							default: phase_q <= PH_QUALITY;
						endcase
					end
					CMD_CLEAR: frame_ready_q <= 1'b0;
					default: ;
				endcase
			end
			if (ctl.wr_en) begin
				stored_q <= 1'b1;
			end
		end
	end

	// Table memory: one write port (clear or live), one registered read port (snapshot)
	always_ff @(posedge clk) begin
		if (ctl.clr_en) begin
			tbl_mem[clr_addr] <= '0;
		end else if (ctl.wr_en) begin
			tbl_mem[wr_addr] <= div_rsp.quotient;
		end
		if (ctl.exec) begin
			rd_data_q <= tbl_mem[rd_addr];
			rd_ok_q   <= (cmd_q == CMD_READ) && rd_in_span;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_data_q <= rd_ok_q ? rd_data_q : '0;
			out_fr_q   <= frame_ready_q;
			out_st_q   <= started_q;
			out_sp_q   <= stored_q;
			out_se_q   <= serr_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.read_data    = out_data_q;
	assign result.frame_ready  = out_fr_q;
	assign result.scan_started = out_st_q;
	assign result.point_stored = out_sp_q;
	assign result.sync_error   = out_se_q;

	// Checks
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_take_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> state_q == ST_EXEC)
		else $error("accepted request did not move to execute");

	a_write_flags: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |=> (stored_q && state_q == ST_FIN))
		else $error("table write without stored flag");

	a_start_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && started_q) |-> frame_ready_q)
		else $error("scan start without frame ready");

endmodule
